// ----- hdl/splitmix_bounded_random_unit_macros.svh -----
// Assertion macros shared by the generator modules.
`ifndef SPLITMIX_BOUNDED_RANDOM_UNIT_MACROS_SVH
`define SPLITMIX_BOUNDED_RANDOM_UNIT_MACROS_SVH

// Check a condition on every clock edge outside reset.
`define SBR_CHECK(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Check that a condition implies a consequence on the same edge.
`define SBR_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ----- hdl/sbr_pkg.sv -----
`default_nettype none
package sbr_pkg;

    localparam logic [2:0] CMD_RAW64 = 3'd0;
    localparam logic [2:0] CMD_RAW32 = 3'd1;
    localparam logic [2:0] CMD_TOP   = 3'd2;
    localparam logic [2:0] CMD_BND32 = 3'd3;
    localparam logic [2:0] CMD_BND64 = 3'd4;

    localparam int unsigned CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_GAMMA = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SEED  = 2'd1;

    localparam logic [63:0] MIX_MUL_A   = 64'hff51afd7ed558ccd;
    localparam logic [63:0] MIX_MUL_B   = 64'hc4ceb9fe1a85ec53;
    localparam logic [63:0] GAMMA_RESET = 64'h9e3779b97f4a7c15;
    localparam logic [63:0] SEED_RESET  = 64'd0;
    localparam int unsigned MIX_SHIFT   = 33;
    localparam logic [6:0]  DRAW_LIMIT  = 7'd64;
    localparam logic [6:0]  DIV_STEPS   = 7'd64;
    localparam logic [5:0]  TOP_MAX     = 6'd32;

    typedef enum logic [2:0] {
        OP_NONE  = 3'd0,
        OP_BAD   = 3'd1,
        OP_RAW64 = 3'd2,
        OP_RAW32 = 3'd3,
        OP_TOP   = 3'd4,
        OP_BMASK = 3'd5,
        OP_BMOD  = 3'd6,
        OP_BOVF  = 3'd7
    } op_t;

    typedef struct packed {
        op_t         op;
        logic        wide;
        logic [63:0] origin;
        logic [63:0] bound;
        logic [63:0] span;
        logic [63:0] span_m1;
        logic [5:0]  bits;
    } entry_t;

    function automatic logic [63:0] fit_width(input logic [63:0] x, input logic wide);
        fit_width = wide ? x : {{32{x[31]}}, x[31:0]};
    endfunction

endpackage
`default_nettype wire

// ----- hdl/sbr_front.sv -----
`default_nettype none
module sbr_front
    import sbr_pkg::*;
(
    input  wire logic               in_valid,
    input  wire logic [2:0]         cmd,
    input  wire logic signed [63:0] range_low,
    input  wire logic signed [63:0] range_high,
    input  wire logic [5:0]         bit_count,
    input  wire logic               q_full,
    output logic                    in_stall,
    output logic                    push,
    output entry_t                  push_entry
);

    logic [31:0] lo32;
    logic [31:0] hi32;
    logic [63:0] n64;
    logic [31:0] n32;
    logic        lt64;
    logic        lt32;
    logic        ok;
    logic        pow2;
    logic        nsign;

    assign in_stall = q_full;
    assign push     = in_valid && !q_full;

    always_comb
    begin
        lo32 = range_low[31:0];
        hi32 = range_high[31:0];
        n64  = range_high - range_low;
        n32  = hi32 - lo32;
        lt64 = range_low < range_high;
        lt32 = $signed(lo32) < $signed(hi32);

        push_entry.wide    = (cmd != CMD_RAW32) && (cmd != CMD_BND32);
        push_entry.origin  = fit_width(range_low, push_entry.wide);
        push_entry.bound   = fit_width(range_high, push_entry.wide);
        push_entry.span    = push_entry.wide ? n64 : {32'd0, n32};
        push_entry.span_m1 = push_entry.wide ? (n64 - 64'd1) : {32'd0, n32 - 32'd1};
        push_entry.bits    = (bit_count > TOP_MAX) ? TOP_MAX : bit_count;

        ok    = push_entry.wide ? lt64 : lt32;
        pow2  = (push_entry.span & push_entry.span_m1) == 64'd0;
        nsign = push_entry.wide ? n64[63] : n32[31];

        unique case (cmd)
            CMD_RAW64: push_entry.op = OP_RAW64;
            CMD_RAW32: push_entry.op = OP_RAW32;
            CMD_TOP:   push_entry.op = OP_TOP;
            CMD_BND32, CMD_BND64:
            begin
                if (!ok)
                    push_entry.op = OP_BAD;
                else if (pow2)
                    push_entry.op = OP_BMASK;
                else if (!nsign)
                    push_entry.op = OP_BMOD;
                else
                    push_entry.op = OP_BOVF;
            end
            default:   push_entry.op = OP_NONE;
        endcase
    end

endmodule
`default_nettype wire

// ----- hdl/sbr_queue.sv -----
`default_nettype none
module sbr_queue
    import sbr_pkg::*;
#(
    parameter int unsigned DEPTH = 2
)
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   push,
    input  wire entry_t push_entry,
    output logic        full,
    input  wire logic   pop_ready,
    output logic        pop_valid,
    output entry_t      pop_entry
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    entry_t           mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             pop;

    assign full      = count_reg == FULL_CNT;
    assign pop_valid = count_reg != '0;
    assign pop       = pop_valid && pop_ready;
    assign pop_entry = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == LAST) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == LAST) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_entry;
    end

`include "splitmix_bounded_random_unit_macros.svh"

    `SBR_CHECK(a_count_bound, count_reg <= FULL_CNT, "queue count above depth")
    `SBR_IMPLY(a_no_overflow, push, !full, "push into full queue")
    `SBR_IMPLY(a_no_underflow, pop, count_reg != '0, "pop from empty queue")

endmodule
`default_nettype wire

// ----- hdl/sbr_back.sv -----
`default_nettype none
module sbr_back
    import sbr_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_valid,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [63:0]          cfg_data,
    input  wire logic                 q_valid,
    input  wire entry_t               q_entry,
    output logic                      q_ready,
    output logic                      out_valid,
    input  wire logic                 out_stall,
    output logic [63:0]               out_value,
    output logic                      out_bad
);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_MUL   = 7'b0000010,
        S_DRAWN = 7'b0000100,
        S_DIV   = 7'b0001000,
        S_CHECK = 7'b0010000,
        S_DONE  = 7'b0100000,
        S_SPARE = 7'b1000000
    } state_t;

    state_t      state_reg, state_next;
    entry_t      cur_reg, cur_next;
    logic [63:0] seed_reg, seed_next;
    logic [63:0] gamma_reg;
    logic [63:0] z_reg, z_next;
    logic [63:0] acc_reg, acc_next;
    logic [1:0]  mstep_reg, mstep_next;
    logic        phase_reg, phase_next;
    logic [63:0] r_reg, r_next;
    logic [63:0] u_reg, u_next;
    logic [63:0] quo_reg, quo_next;
    logic [63:0] rem_reg, rem_next;
    logic [6:0]  cnt_reg, cnt_next;
    logic [6:0]  draws_reg, draws_next;
    logic [63:0] res_reg, res_next;
    logic        bad_reg, bad_next;
    logic        out_valid_reg, out_valid_next;
    logic [63:0] out_value_reg, out_value_next;
    logic        out_bad_reg, out_bad_next;

    logic [63:0] mul_const;
    logic [31:0] mul_a;
    logic [31:0] mul_b;
    logic [63:0] prod;
    logic [63:0] ext_r;
    logic [63:0] rem_sh;
    logic [63:0] chk;
    logic        start_draw;

    assign q_ready   = state_reg == S_IDLE;
    assign out_valid = out_valid_reg;
    assign out_value = out_value_reg;
    assign out_bad   = out_bad_reg;

    assign mul_const = phase_reg ? MIX_MUL_B : MIX_MUL_A;
    assign mul_a     = (mstep_reg == 2'd1) ? z_reg[63:32] : z_reg[31:0];
    assign mul_b     = (mstep_reg == 2'd2) ? mul_const[63:32] : mul_const[31:0];
    assign prod      = {32'd0, mul_a} * {32'd0, mul_b};
    assign ext_r     = fit_width(r_reg, cur_reg.wide);
    assign rem_sh    = {rem_reg[62:0], quo_reg[63]};
    assign chk       = u_reg + cur_reg.span_m1 - rem_reg;

    always_comb
    begin
        state_next     = state_reg;
        cur_next       = cur_reg;
        seed_next      = seed_reg;
        z_next         = z_reg;
        acc_next       = acc_reg;
        mstep_next     = mstep_reg;
        phase_next     = phase_reg;
        r_next         = r_reg;
        u_next         = u_reg;
        quo_next       = quo_reg;
        rem_next       = rem_reg;
        cnt_next       = cnt_reg;
        draws_next     = draws_reg;
        res_next       = res_reg;
        bad_next       = bad_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_value_next = out_value_reg;
        out_bad_next   = out_bad_reg;
        start_draw     = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (q_valid)
                begin
                    cur_next   = q_entry;
                    draws_next = 7'd0;
                    res_next   = 64'd0;
                    bad_next   = q_entry.op == OP_BAD;
                    if (q_entry.op == OP_BAD || q_entry.op == OP_NONE)
                        state_next = S_DONE;
                    else
                        start_draw = 1'b1;
                end
            end
            S_MUL:
            begin
                mstep_next = mstep_reg + 2'd1;
                case (mstep_reg)
                    2'd0: acc_next = prod;
                    2'd3:
                    begin
                        mstep_next = 2'd0;
                        if (!phase_reg)
                        begin
                            z_next     = acc_reg ^ (acc_reg >> MIX_SHIFT);
                            phase_next = 1'b1;
                        end
                        else
                        begin
                            r_next     = cur_reg.wide ? (acc_reg ^ (acc_reg >> MIX_SHIFT))
                                                      : {32'd0, acc_reg[63:32]};
                            state_next = S_DRAWN;
                        end
                    end
                    default: acc_next = acc_reg + {prod[31:0], 32'd0};
                endcase
            end
            S_DRAWN:
            begin
                state_next = S_DONE;
                case (cur_reg.op)
                    OP_RAW64: res_next = r_reg;
                    OP_RAW32: res_next = ext_r;
                    OP_TOP:
                        res_next = (cur_reg.bits == 6'd0) ? 64'd0
                                 : r_reg >> (7'd64 - {1'b0, cur_reg.bits});
                    OP_BMASK:
                        res_next = fit_width((r_reg & cur_reg.span_m1) + cur_reg.origin,
                                             cur_reg.wide);
                    OP_BMOD:
                    begin
                        u_next     = cur_reg.wide ? {1'b0, r_reg[63:1]} : {33'd0, r_reg[31:1]};
                        quo_next   = u_next;
                        rem_next   = 64'd0;
                        cnt_next   = DIV_STEPS;
                        state_next = S_DIV;
                    end
                    OP_BOVF:
                    begin
                        if ($signed(ext_r) >= $signed(cur_reg.origin)
                            && $signed(ext_r) < $signed(cur_reg.bound))
                            res_next = ext_r;
                        else if (draws_reg >= DRAW_LIMIT)
                            res_next = cur_reg.origin;
                        else
                        begin
                            state_next = S_DRAWN;
                            start_draw = 1'b1;
                        end
                    end
                    default: res_next = 64'd0;
                endcase
            end
            S_DIV:
            begin
                rem_next = (rem_sh >= cur_reg.span) ? (rem_sh - cur_reg.span) : rem_sh;
                quo_next = {quo_reg[62:0], 1'b0};
                cnt_next = cnt_reg - 7'd1;
                if (cnt_reg == 7'd1)
                    state_next = S_CHECK;
            end
            S_CHECK:
            begin
                if (!(cur_reg.wide ? chk[63] : chk[31]) || draws_reg >= DRAW_LIMIT)
                begin
                    res_next   = fit_width(rem_reg + cur_reg.origin, cur_reg.wide);
                    state_next = S_DONE;
                end
                else
                    start_draw = 1'b1;
            end
            S_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    out_value_next = res_reg;
                    out_bad_next   = bad_reg;
                    state_next     = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase

        if (start_draw)
        begin
            z_next     = seed_reg ^ (seed_reg >> MIX_SHIFT);
            seed_next  = seed_reg + gamma_reg;
            draws_next = draws_next + 7'd1;
            phase_next = 1'b0;
            mstep_next = 2'd0;
            state_next = S_MUL;
        end

        if (cfg_valid && cfg_index == CFG_SEED)
            seed_next = cfg_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            seed_reg      <= SEED_RESET;
            gamma_reg     <= GAMMA_RESET;
            out_valid_reg <= 1'b0;
            draws_reg     <= 7'd0;
            cnt_reg       <= 7'd0;
            mstep_reg     <= 2'd0;
            phase_reg     <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            seed_reg      <= seed_next;
            out_valid_reg <= out_valid_next;
            draws_reg     <= draws_next;
            cnt_reg       <= cnt_next;
            mstep_reg     <= mstep_next;
            phase_reg     <= phase_next;
            if (cfg_valid && cfg_index == CFG_GAMMA)
                gamma_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg       <= cur_next;
        z_reg         <= z_next;
        acc_reg       <= acc_next;
        r_reg         <= r_next;
        u_reg         <= u_next;
        quo_reg       <= quo_next;
        rem_reg       <= rem_next;
        res_reg       <= res_next;
        bad_reg       <= bad_next;
        out_value_reg <= out_value_next;
        out_bad_reg   <= out_bad_next;
    end

`include "splitmix_bounded_random_unit_macros.svh"

    `SBR_CHECK(a_draw_limit, draws_reg <= DRAW_LIMIT, "draw count above limit")
    `SBR_IMPLY(a_rem_below_span, state_reg == S_DIV || state_reg == S_CHECK,
               rem_reg < cur_reg.span, "remainder not below span")
    `SBR_IMPLY(a_bad_no_draw, state_reg == S_DONE && bad_reg, draws_reg == 7'd0,
               "seed advanced on bad range")

endmodule
`default_nettype wire

// ----- hdl/splitmix_bounded_random_unit.sv -----
// Channel   Handshake            Beat
// in        in_valid / in_stall  cmd, range_low, range_high, bit_count
// out       out_valid / out_stall value, bad_range
// cfg       cfg_valid / cfg_ready cfg_index, cfg_data
//
// Each draw runs two 64-bit mixes on one shared 32x32 multiplier.
// Raw and mask commands take one draw; modulo draws add a bit-serial
// remainder per draw, up to 64 draws when candidates are rejected.
// Reset loads gamma 0x9e3779b97f4a7c15 and seed 0; no clearing pass.
// A result register and the front queue let input beats land while out stalls.
`default_nettype none
module splitmix_bounded_random_unit
    import sbr_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = 2
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_stall,
    input  wire logic [2:0]           cmd,
    input  wire logic signed [63:0]   range_low,
    input  wire logic signed [63:0]   range_high,
    input  wire logic [5:0]           bit_count,
    output logic                      out_valid,
    input  wire logic                 out_stall,
    output logic signed [63:0]        value,
    output logic                      bad_range,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [63:0]          cfg_data
);

    entry_t      push_entry;
    entry_t      pop_entry;
    logic        push;
    logic        q_full;
    logic        pop_valid;
    logic        pop_ready;
    logic [63:0] out_value;

    assign cfg_ready = 1'b1;
    assign value     = out_value;

    sbr_front u_front (
        .in_valid   (in_valid),
        .cmd        (cmd),
        .range_low  (range_low),
        .range_high (range_high),
        .bit_count  (bit_count),
        .q_full     (q_full),
        .in_stall   (in_stall),
        .push       (push),
        .push_entry (push_entry)
    );

    sbr_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .full       (q_full),
        .pop_ready  (pop_ready),
        .pop_valid  (pop_valid),
        .pop_entry  (pop_entry)
    );

    sbr_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .q_valid   (pop_valid),
        .q_entry   (pop_entry),
        .q_ready   (pop_ready),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_value (out_value),
        .out_bad   (bad_range)
    );

endmodule
`default_nettype wire
